// File: hw/rtl/patl_pkg.sv
package patl_pkg;

    // Sonar readings above this distance count as no echo.
    localparam int unsigned MAX_DISTANCE = 500;

    localparam int unsigned DIST_W   = 9;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned SEC_W    = 10;
    localparam int unsigned LAMP_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [SEC_W-1:0] MS_PER_SEC = SEC_W'(1000);
    localparam logic [MS_W-1:0]  MS_SAT     = '1;

    localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE     = 3'd0,
        CFG_MAX_RANGE     = 3'd1,
        CFG_POLL_INTERVAL = 3'd2,
        CFG_INITIAL_GREEN = 3'd3,
        CFG_EXTENSION     = 3'd4,
        CFG_YELLOW        = 3'd5
    } t_cfg_index;

    typedef enum logic [3:0] {
        PH_RED_IDLE = 4'b0001,
        PH_GREEN    = 4'b0010,
        PH_YELLOW   = 4'b0100,
        PH_RED_STOP = 4'b1000
    } t_phase;

    typedef struct packed {
        logic              stop_request;
        logic [DIST_W-1:0] distance_cm;
    } t_in;

    typedef struct packed {
        logic [LAMP_W-1:0] lamp;
        logic              sensor_sampled;
        logic              display_write;
        logic [SEC_W-1:0]  display_value;
        logic              display_clear;
    } t_out;

    typedef struct packed {
        logic [DIST_W-1:0] range_lo_cm;
        logic [DIST_W-1:0] range_hi_cm;
        logic [MS_W-1:0]   poll_interval_ms;
        logic [SEC_W-1:0]  initial_green_sec;
        logic [SEC_W-1:0]  extension_sec;
        logic [MS_W-1:0]   yellow_ms;
    } t_cfg;

endpackage

// File: hw/rtl/patl_cfg_regs.sv
module patl_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [patl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [patl_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output patl_pkg::t_cfg                 o_cfg
);
    import patl_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_lo_cm       <= DIST_W'(5);
            r_cfg.range_hi_cm       <= DIST_W'(50);
            r_cfg.poll_interval_ms  <= MS_W'(100);
            r_cfg.initial_green_sec <= SEC_W'(10);
            r_cfg.extension_sec     <= SEC_W'(5);
            r_cfg.yellow_ms         <= MS_W'(3000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MIN_RANGE:     r_cfg.range_lo_cm       <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_RANGE:     r_cfg.range_hi_cm       <= i_cfg_data[DIST_W-1:0];
                CFG_POLL_INTERVAL: r_cfg.poll_interval_ms  <= i_cfg_data[MS_W-1:0];
                CFG_INITIAL_GREEN: r_cfg.initial_green_sec <= i_cfg_data[SEC_W-1:0];
                CFG_EXTENSION:     r_cfg.extension_sec     <= i_cfg_data[SEC_W-1:0];
                CFG_YELLOW:        r_cfg.yellow_ms         <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/patl_ctrl.sv
module patl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  patl_pkg::t_cfg i_cfg,
    input  logic           i_step,
    input  patl_pkg::t_in  i_item,
    output patl_pkg::t_out o_result
);
    import patl_pkg::*;

    t_phase           r_phase, n_phase;
    logic [MS_W-1:0]  r_poll, n_poll;
    logic [SEC_W-1:0] r_gsl, n_gsl;
    logic [SEC_W-1:0] r_sub, n_sub;
    logic [MS_W-1:0]  r_ye, n_ye;
    logic             r_sv, n_sv;
    logic [SEC_W-1:0] r_ss, n_ss;

    logic             present;
    logic [MS_W-1:0]  poll_inc;
    logic [MS_W-1:0]  ye_inc;
    logic [SEC_W-1:0] sub_inc;
    logic             sec_roll;
    logic [SEC_W-1:0] gsl_after;
    logic             show_req;
    logic             show_force;
    logic [SEC_W-1:0] show_secs;
    t_out             res;

    // object present: echo, within sonar reach, inside the configured window
    assign present = (i_item.distance_cm != '0)
                  && ({1'b0, i_item.distance_cm} <= 10'(MAX_DISTANCE))
                  && (i_item.distance_cm >= i_cfg.range_lo_cm)
                  && (i_item.distance_cm <= i_cfg.range_hi_cm);

    assign poll_inc  = (r_poll == MS_SAT) ? r_poll : r_poll + MS_W'(1);
    assign ye_inc    = (r_ye == MS_SAT) ? r_ye : r_ye + MS_W'(1);
    assign sub_inc   = r_sub + SEC_W'(1);
    assign sec_roll  = (sub_inc >= MS_PER_SEC);
    assign gsl_after = sec_roll ? r_gsl - SEC_W'(1) : r_gsl;

    always_comb begin
        n_phase    = r_phase;
        n_poll     = r_poll;
        n_gsl      = r_gsl;
        n_sub      = r_sub;
        n_ye       = r_ye;
        n_sv       = r_sv;
        n_ss       = r_ss;
        res        = '0;
        show_req   = 1'b0;
        show_force = 1'b0;
        show_secs  = '0;

        if (i_item.stop_request && (r_phase inside {PH_RED_IDLE, PH_GREEN})) begin
            n_phase           = PH_YELLOW;
            n_ye              = '0;
            n_sv              = 1'b0;
            res.display_clear = 1'b1;
        end else begin
            case (r_phase)
                PH_RED_IDLE: begin
                    if (poll_inc >= i_cfg.poll_interval_ms) begin
                        n_poll             = '0;
                        res.sensor_sampled = 1'b1;
                        if (present) begin
                            n_phase    = PH_GREEN;
                            n_gsl      = i_cfg.initial_green_sec;
                            n_sub      = '0;
                            show_req   = 1'b1;
                            show_force = 1'b1;
                            show_secs  = i_cfg.initial_green_sec;
                        end
                    end else begin
                        n_poll = poll_inc;
                    end
                end
                PH_GREEN: begin
                    if (r_gsl != '0) begin
                        n_sub = sec_roll ? '0 : sub_inc;
                        n_gsl = gsl_after;
                    end
                    if (r_gsl != '0 && gsl_after != '0) begin
                        show_req  = 1'b1;
                        show_secs = gsl_after;
                    end else begin
                        // expiry: extend on presence, else back to red idle
                        res.sensor_sampled = 1'b1;
                        if (present) begin
                            n_gsl      = i_cfg.extension_sec;
                            n_sub      = '0;
                            show_req   = 1'b1;
                            show_force = 1'b1;
                            show_secs  = i_cfg.extension_sec;
                        end else begin
                            n_phase           = PH_RED_IDLE;
                            n_poll            = MS_SAT;
                            n_sv              = 1'b0;
                            res.display_clear = 1'b1;
                        end
                    end
                end
                PH_YELLOW: begin
                    n_ye = ye_inc;
                    if (ye_inc >= i_cfg.yellow_ms) begin
                        n_phase = PH_RED_STOP;
                    end
                end
                default: begin
                end
            endcase
        end

        // write the display when the shown number changes, or when forced at a new green or extension
        if (show_req && (show_force || !r_sv || r_ss != show_secs)) begin
            res.display_write = 1'b1;
            res.display_value = show_secs;
            n_sv              = 1'b1;
            n_ss              = show_secs;
        end

        case (n_phase)
            PH_GREEN:  res.lamp = LAMP_GREEN;
            PH_YELLOW: res.lamp = LAMP_YELLOW;
            default:   res.lamp = LAMP_RED;
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RED_IDLE;
            r_poll  <= '0;
            r_gsl   <= '0;
            r_sub   <= '0;
            r_ye    <= '0;
            r_sv    <= 1'b0;
            r_ss    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_poll  <= n_poll;
            r_gsl   <= n_gsl;
            r_sub   <= n_sub;
            r_ye    <= n_ye;
            r_sv    <= n_sv;
            r_ss    <= n_ss;
        end
    end

`ifndef SYNTHESIS
    a_stop_to_yellow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.stop_request && (r_phase == PH_RED_IDLE || r_phase == PH_GREEN))
        |=> (r_phase == PH_YELLOW))
        else $error("stop request did not light yellow");

    a_red_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RED_STOP) |=> (r_phase == PH_RED_STOP))
        else $error("left terminal red");

    a_write_in_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.display_write |-> (o_result.lamp == LAMP_GREEN && !o_result.display_clear))
        else $error("display write outside green");
`endif

endmodule

// File: hw/rtl/presence_actuated_traffic_light_top.sv
// Presence-actuated traffic light controller.
// Input channel: one beat per millisecond tick (i_in_data: stop_request,
//   distance_cm); accepted when i_in_valid is high and o_in_stall is low.
// Output channel: one result beat per tick (lamp, sensor_sampled,
//   display_write, display_value, display_clear); taken when o_out_valid is
//   high and i_out_stall is low.
// Config channel: i_cfg_valid/o_cfg_ready with a register index and data;
//   o_cfg_ready is always high. Write only while no tick is in flight.
// Path: an accepted tick waits in the input register, is evaluated on its
//   step, and its result beat is then presented from the result register.
// Throughput: one tick per cycle while the result register is not held by i_out_stall. The
//   state update is a few counter increments and compares between the input register and result register.
// Stall: while the result register waits on i_out_stall, one more tick is
//   taken into the input register; o_in_stall rises only when both are full.
// Reset (i_rst_n low at a clock edge): light is red idle, counters and the
//   display tracking clear, registers return to their defaults, no beat
//   is held on either side.
module presence_actuated_traffic_light_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  patl_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output patl_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [patl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [patl_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import patl_pkg::*;

    t_cfg cfg;
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    t_out result;
    logic out_blocked;
    logic step;
    logic in_accept;

    // result register full and held by the receiver
    assign out_blocked = r_out_valid && i_out_stall;
    // advance the held tick whenever the result register can take its beat
    assign step        = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_accept   = i_in_valid && !o_in_stall;

    patl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    patl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    // input register: hold the beat until it is evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // result register: load on step, drop once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_step_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("evaluated tick produced no result beat");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room to spare");

    a_blocked_holds_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_blocked) |=> r_in_valid)
        else $error("held tick lost while output blocked");
`endif

endmodule
